// ===== hw/rtl/asp_pkg.sv =====
// Shared constants, types and palette for the ANSI colour escape parser.
package asp_pkg;

	// Parameter store depth and the counter and index widths that follow from it
	localparam int MAX_PARAMS = 8;
	localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W      = $clog2(MAX_PARAMS);

	// Only the first five codes ever take part in a colour change
	localparam int SGR_ARGS   = 5;

	localparam int CHAR_W     = 16;
	localparam int COLOUR_W   = 32;

	typedef logic [CHAR_W-1:0]               char_t;
	typedef logic [COLOUR_W-1:0]             colour_t;
	typedef logic [CNT_W-1:0]                count_t;
	typedef logic [SGR_ARGS-1:0][CHAR_W-1:0] sgr_args_t;

	// Characters of interest
	localparam char_t CH_ESC   = 16'h001b;
	localparam char_t CH_LBR   = 16'h005b;
	localparam char_t CH_SEMI  = 16'h003b;
	localparam char_t CH_M     = 16'h006d;
	localparam char_t CH_ZERO  = 16'h0030;
	localparam char_t CH_NINE  = 16'h0039;

	// SGR codes understood
	localparam char_t SGR_RESET    = 16'd0;
	localparam char_t SGR_FG_EXT   = 16'd38;
	localparam char_t SGR_EXT_RGB  = 16'd2;
	localparam char_t SGR_FG_FIRST = 16'd30;
	localparam char_t SGR_FG_LAST  = 16'd37;

	localparam colour_t COLOUR_WHITE = 32'hffffffff;
	localparam colour_t ALPHA_OPAQUE = 32'hff000000;

	// Eight-entry foreground palette
	function automatic colour_t palette(input logic [2:0] sel);
		colour_t c;
		unique case (sel)
			3'd0: c = 32'hff000000;
			3'd1: c = 32'hffcc0000;
			3'd2: c = 32'hff009a00;
			3'd3: c = 32'hffc4a000;
			3'd4: c = 32'hff0065a4;
			3'd5: c = 32'hff75507b;
			3'd6: c = 32'hff00989a;
			3'd7: c = 32'hffd0d0d0;
			default: c = COLOUR_WHITE;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/asp_sgr_apply.sv =====
// Works out the colour that a completed SGR sequence leaves behind.
module asp_sgr_apply
	import asp_pkg::*;
(
	input  count_t    count,
	input  sgr_args_t args,
	input  colour_t   colour,
	output colour_t   colour_next
);

	char_t       sel_off;

	assign sel_off = args[1] - SGR_FG_FIRST;

	// First code picks the form; anything unrecognised leaves the colour alone
	always_comb begin
		colour_next = colour;
		if (count == '0) begin
			colour_next = COLOUR_WHITE;
		end else if (args[0] == SGR_RESET) begin
			if (count >= CNT_W'(2) && args[1] >= SGR_FG_FIRST && args[1] <= SGR_FG_LAST) begin
				colour_next = palette(sel_off[2:0]);
			end
		end else if (args[0] == SGR_FG_EXT) begin
			if (count >= CNT_W'(5) && args[1] == SGR_EXT_RGB) begin
				colour_next = ALPHA_OPAQUE | {8'h00, args[2][7:0], args[3][7:0], args[4][7:0]};
			end
		end
	end

endmodule

// ===== hw/rtl/ansi_colour_escape_parser.sv =====
// Top level of the ANSI colour escape parser: input register, parse state, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------
//  in      | in        | in_valid/in_stall  | char_code[15:0]
//  out     | out       | out_valid/out_stall| glyph[15:0], glyph_colour[31:0]
//
// One item per cycle sustained while the output is not stalled. A printable item passes
// through the input register and the result register before it is offered at the output.
// Escape, parameter and terminator characters produce no result item.
// Reset clears the parse state and sets the colour to opaque white.
// A stall while the output is valid holds the result register and, once the input register is
// also full, raises in_stall in the same cycle.
module ansi_colour_escape_parser
	import asp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  char_t   char_code,
	output logic    out_valid,
	input  logic    out_stall,
	output char_t   glyph,
	output colour_t glyph_colour
);

	localparam logic [1:0] MODE_PRINT = 2'd0;
	localparam logic [1:0] MODE_ESC   = 2'd1;
	localparam logic [1:0] MODE_VALUE = 2'd2;
	localparam logic [1:0] MODE_END   = 2'd3;

	logic                  valid_s1;
	char_t                 char_s1;
	logic                  advance;

	logic [1:0]            mode_q, mode_d;
	count_t                count_q, count_d;
	char_t                 acc_q, acc_d;
	colour_t               colour_q, colour_d;
	char_t                 store_q [MAX_PARAMS];

	logic                  store_we;
	logic [IDX_W-1:0]      wr_idx;
	logic                  is_digit;
	logic [CHAR_W+3:0]     acc_mac;
	count_t                count_eff;
	sgr_args_t             args;
	colour_t               colour_applied;

	logic                  emit;
	logic                  out_valid_q;
	char_t                 glyph_q;
	colour_t               colour_out_q;

	// Stage one moves on whenever the result register is free or being emptied
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	// Decimal accumulate: acc*10 + digit, saturating
	assign is_digit = char_s1 >= CH_ZERO && char_s1 <= CH_NINE;
	assign acc_mac  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
	                + {4'b0, char_s1 - CH_ZERO};

	// Parameter write when a number ends and there is room
	assign wr_idx    = count_q[IDX_W-1:0];
	assign store_we  = valid_s1 && advance && mode_q == MODE_VALUE && !is_digit
	                && count_q < CNT_W'(MAX_PARAMS);
	assign count_eff = store_we ? count_q + CNT_W'(1) : count_q;

	// Codes as they stand after this item's write, so an 'm' sees its own number
	always_comb begin
		for (int k = 0; k < SGR_ARGS; k++) begin
			args[k] = (store_we && wr_idx == IDX_W'(k)) ? acc_q : store_q[k];
		end
	end

	asp_sgr_apply u_apply (
		.count       (count_eff),
		.args        (args),
		.colour      (colour_q),
		.colour_next (colour_applied)
	);

	// Parse state machine
	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		acc_d    = acc_q;
		colour_d = colour_q;
		emit     = 1'b0;
		if (valid_s1 && advance) begin
			unique case (mode_q)
				MODE_PRINT: begin
					if (char_s1 == CH_ESC) begin
						mode_d = MODE_ESC;
					end else begin
						emit = 1'b1;
					end
				end
				MODE_ESC: begin
					if (char_s1 == CH_LBR) begin
						count_d = '0;
						acc_d   = '0;
						mode_d  = MODE_VALUE;
					end else begin
						mode_d  = MODE_PRINT;
					end
				end
				MODE_VALUE, MODE_END: begin
					if (mode_q == MODE_VALUE && is_digit) begin
						acc_d = (acc_mac > {4'b0, 16'hffff}) ? 16'hffff : acc_mac[CHAR_W-1:0];
					end else begin
						count_d = count_eff;
						priority if (char_s1 == CH_SEMI) begin
							acc_d  = '0;
							mode_d = MODE_VALUE;
						end else if (char_s1 == CH_M) begin
							colour_d = colour_applied;
							mode_d   = MODE_PRINT;
						end else begin
							mode_d   = MODE_END;
						end
					end
				end
				default: mode_d = MODE_PRINT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PRINT;
			count_q  <= '0;
			acc_q    <= '0;
			colour_q <= COLOUR_WHITE;
		end else begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			acc_q    <= acc_d;
			colour_q <= colour_d;
		end
	end

	// Parameter store
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[wr_idx] <= acc_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			glyph_q      <= char_s1;
			colour_out_q <= colour_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign glyph        = glyph_q;
	assign glyph_colour = colour_out_q;

endmodule
